### rtl/fsmet_pkg.sv
// Shared constants for the frustum segment metrics block.
// No dependencies; the other rtl files that use it refer to it by scoped names.
package fsmet_pkg;

    localparam int OUT_WIDTH   = 48;
    localparam int PI_FRAC     = 48;
    localparam logic [47:0] PI12_Q48 = 48'd73689976583630;
    localparam logic [47:0] PI4_Q48  = 48'd221069929750889;
    localparam int QUEUE_DEPTH = 4;
    localparam int MUL_CHUNK   = 32;
    localparam int MUL_LAT     = 2;

endpackage

### rtl/fsmet_mul.sv
// Two-stage unsigned multiplier built from 32x32 partial products.
// Depends on fsmet_pkg for the chunk width.
module fsmet_mul #(
    parameter int AW = 32,
    parameter int BW = 32
) (
    input  logic             aclk,
    input  logic             en,
    input  logic [AW-1:0]    a,
    input  logic [BW-1:0]    b,
    output logic [AW+BW-1:0] p
);
    localparam int CW  = fsmet_pkg::MUL_CHUNK;
    localparam int NA  = (AW + CW - 1) / CW;
    localparam int NB  = (BW + CW - 1) / CW;
    localparam int APW = NA * CW;
    localparam int BPW = NB * CW;
    localparam int PWD = AW + BW;

    logic [APW-1:0]  a_pad;
    logic [BPW-1:0]  b_pad;
    logic [2*CW-1:0] pp_reg [NA][NB];
    logic [PWD-1:0]  sum_next;
    logic [PWD-1:0]  p_reg;

    assign a_pad = APW'(a);
    assign b_pad = BPW'(b);

    always_comb begin
        sum_next = '0;
        for (int i = 0; i < NA; i++) begin
            for (int j = 0; j < NB; j++) begin
                sum_next = sum_next + (PWD'(pp_reg[i][j]) << (CW * (i + j)));
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < NA; i++) begin
                for (int j = 0; j < NB; j++) begin
                    pp_reg[i][j] <= a_pad[i*CW +: CW] * b_pad[j*CW +: CW];
                end
            end
            p_reg <= sum_next;
        end
    end

    assign p = p_reg;

endmodule

### rtl/fsmet_sqrt.sv
// Pipelined integer square root, one result bit per stage, floor rounding.
// Carries a payload and a valid bit alongside; no package dependencies.
module fsmet_sqrt #(
    parameter int IW = 50,
    parameter int PW = 1
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            en,
    input  logic            in_valid,
    input  logic [IW-1:0]   n,
    input  logic [PW-1:0]   pay_in,
    output logic            out_valid,
    output logic [IW/2-1:0] root,
    output logic [PW-1:0]   pay_out
);
    localparam int OW = IW / 2;

    logic [OW:0]   rem_reg   [OW];
    logic [OW-1:0] root_reg  [OW];
    logic [IW-1:0] n_reg     [OW];
    logic [PW-1:0] pay_reg   [OW];
    logic [OW-1:0] v_reg;
    logic [OW:0]   rem_next  [OW];
    logic [OW-1:0] root_next [OW];
    logic [IW-1:0] n_next    [OW];
    logic [PW-1:0] pay_next  [OW];
    logic [OW-1:0] v_next;

    always_comb begin
        logic [OW:0]   rem_p;
        logic [OW-1:0] root_p;
        logic [IW-1:0] n_p;
        logic [OW+2:0] r2;
        logic [OW+2:0] trial;
        for (int k = 0; k < OW; k++) begin
            if (k == 0) begin
                rem_p       = '0;
                root_p      = '0;
                n_p         = n;
                pay_next[k] = pay_in;
                v_next[k]   = in_valid;
            end else begin
                rem_p       = rem_reg[k-1];
                root_p      = root_reg[k-1];
                n_p         = n_reg[k-1];
                pay_next[k] = pay_reg[k-1];
                v_next[k]   = v_reg[k-1];
            end
            r2    = {rem_p, n_p[IW-1 -: 2]};
            trial = (OW+3)'({root_p, 2'b01});
            if (r2 >= trial) begin
                rem_next[k]  = (OW+1)'(r2 - trial);
                root_next[k] = {root_p[OW-2:0], 1'b1};
            end else begin
                rem_next[k]  = (OW+1)'(r2);
                root_next[k] = {root_p[OW-2:0], 1'b0};
            end
            n_next[k] = n_p << 2;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int k = 0; k < OW; k++) begin
                rem_reg[k]  <= rem_next[k];
                root_reg[k] <= root_next[k];
                n_reg[k]    <= n_next[k];
                pay_reg[k]  <= pay_next[k];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else if (en) begin
            v_reg <= v_next;
        end
    end

    assign out_valid = v_reg[OW-1];
    assign root      = root_reg[OW-1];
    assign pay_out   = pay_reg[OW-1];

endmodule

### rtl/fsmet_queue.sv
// Short first-in first-out queue between the front and back parts.
// Depends on fsmet_pkg for its depth.
module fsmet_queue #(
    parameter int W = 8
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         push,
    input  logic [W-1:0] wdata,
    output logic         full,
    input  logic         pop,
    output logic         not_empty,
    output logic [W-1:0] rdata
);
    localparam int D    = fsmet_pkg::QUEUE_DEPTH;
    localparam int AWD  = $clog2(D);
    localparam int CNTW = $clog2(D + 1);

    logic [W-1:0]    mem_reg [D];
    logic [AWD-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [AWD-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CNTW-1:0] cnt_reg, cnt_next;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == AWD'(D - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == AWD'(D - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            cnt_next = cnt_reg + 1'b1;
        end else if (pop && !push) begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= wdata;
        end
    end

    assign full      = (cnt_reg == CNTW'(D));
    assign not_empty = (cnt_reg != '0);
    assign rdata     = mem_reg[rd_ptr_reg];

endmodule

### rtl/fsmet_front.sv
// Front part: takes input transfers and forms coordinate distances and diameters.
// Feeds the queue; no package dependencies.
module fsmet_front #(
    parameter int C = 24
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_tvalid,
    output logic           s_tready,
    input  logic [8*C-1:0] s_tdata,
    input  logic           q_full,
    output logic           q_push,
    output logic [5*C-1:0] q_data
);
    logic [C-1:0] dx_reg, dy_reg, dz_reg, d1_reg, d2_reg;
    logic         fv_reg;

    function automatic logic [C-1:0] abs_diff(input logic [C-1:0] a, input logic [C-1:0] b);
        logic [C:0] d;
        d = {a[C-1], a} - {b[C-1], b};
        abs_diff = d[C] ? C'(-d) : d[C-1:0];
    endfunction

    assign q_push   = fv_reg && !q_full;
    assign s_tready = !fv_reg || !q_full;
    assign q_data   = {d2_reg, d1_reg, dz_reg, dy_reg, dx_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fv_reg <= 1'b0;
        end else if (s_tvalid && s_tready) begin
            fv_reg <= 1'b1;
        end else if (q_push) begin
            fv_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            dx_reg <= abs_diff(s_tdata[0*C +: C], s_tdata[4*C +: C]);
            dy_reg <= abs_diff(s_tdata[1*C +: C], s_tdata[5*C +: C]);
            dz_reg <= abs_diff(s_tdata[2*C +: C], s_tdata[6*C +: C]);
            d1_reg <= s_tdata[3*C +: C];
            d2_reg <= s_tdata[7*C +: C];
        end
    end

endmodule

### rtl/fsmet_back.sv
// Back part: squares, two square roots, the volume and area products, clipping.
// Depends on fsmet_pkg, fsmet_sqrt and fsmet_mul.
module fsmet_back #(
    parameter int C  = 24,
    parameter int F  = 8,
    parameter int MW = 128
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           q_valid,
    input  logic [5*C-1:0] q_data,
    output logic           q_pop,
    output logic           m_tvalid,
    input  logic           m_tready,
    output logic [MW-1:0]  m_tdata,
    output logic           m_tuser
);
    localparam int OW  = fsmet_pkg::OUT_WIDTH;
    localparam int SQW = 2*C + 2;
    localparam int LW  = C + 1;
    localparam int QW  = 2*C + 4;
    localparam int HW  = C + 2;
    localparam int VW  = LW + SQW;
    localparam int AW2 = (C + 1) + HW;
    localparam int VFW = VW + fsmet_pkg::PI_FRAC;
    localparam int AFW = AW2 + fsmet_pkg::PI_FRAC;
    localparam int VSH = 2*F + fsmet_pkg::PI_FRAC;
    localparam int ASH = F + fsmet_pkg::PI_FRAC;
    localparam int DL  = 2 * fsmet_pkg::MUL_LAT;
    localparam int P1W = SQW + C + C + 1;
    localparam int P2W = LW + SQW + C + 1;

    logic en;
    logic [C-1:0] dx, dy, dz, d1, d2;

    logic [2*C-1:0] sx_reg, sy_reg, sz_reg, p11_reg, p22_reg, p12_reg;
    logic [C-1:0]   dd1_reg;
    logic [C:0]     ds1_reg;
    logic           v1_reg;

    logic [SQW-1:0] sq2_reg, s2_reg;
    logic [C-1:0]   dd2_reg;
    logic [C:0]     ds2_reg;
    logic           v2_reg;

    logic           l_valid;
    logic [LW-1:0]  l_root;
    logic [P1W-1:0] l_pay;
    logic [SQW-1:0] l_s;
    logic [C-1:0]   l_dd;
    logic [C:0]     l_ds;

    logic [LW-1:0]   len3_reg;
    logic [2*LW-1:0] lsq3_reg;
    logic [2*C-1:0]  ddsq3_reg;
    logic [SQW-1:0]  s3_reg;
    logic [C:0]      ds3_reg;
    logic            v3_reg;

    logic [QW-1:0]  q4_reg;
    logic [LW-1:0]  len4_reg;
    logic [SQW-1:0] s4_reg;
    logic [C:0]     ds4_reg;
    logic           v4_reg;

    logic           h_valid;
    logic [HW-1:0]  h_root;
    logic [P2W-1:0] h_pay;
    logic [LW-1:0]  h_len;
    logic [SQW-1:0] h_s;
    logic [C:0]     h_ds;

    logic [VW-1:0]  pv;
    logic [AW2-1:0] pa;
    logic [VFW-1:0] pvf;
    logic [AFW-1:0] paf;

    logic [LW-1:0] lend_reg [DL];
    logic [DL-1:0] vd_reg;

    logic          vsat, asat;
    logic          m_tvalid_reg;
    logic [C+1:0]  len_out_reg;
    logic [OW-1:0] vol_reg, area_reg;
    logic          sat_reg;

    assign en    = !m_tvalid_reg || m_tready;
    assign q_pop = en && q_valid;
    assign {d2, d1, dz, dy, dx} = q_data;

    always_ff @(posedge aclk) begin
        if (en) begin
            sx_reg  <= dx * dx;
            sy_reg  <= dy * dy;
            sz_reg  <= dz * dz;
            p11_reg <= d1 * d1;
            p22_reg <= d2 * d2;
            p12_reg <= d1 * d2;
            dd1_reg <= (d1 >= d2) ? d1 - d2 : d2 - d1;
            ds1_reg <= (C+1)'(d1) + (C+1)'(d2);

            sq2_reg <= SQW'(sx_reg) + SQW'(sy_reg) + SQW'(sz_reg);
            s2_reg  <= SQW'(p11_reg) + SQW'(p22_reg) + SQW'(p12_reg);
            dd2_reg <= dd1_reg;
            ds2_reg <= ds1_reg;

            len3_reg  <= l_root;
            lsq3_reg  <= l_root * l_root;
            ddsq3_reg <= l_dd * l_dd;
            s3_reg    <= l_s;
            ds3_reg   <= l_ds;

            q4_reg   <= QW'(ddsq3_reg) + (QW'(lsq3_reg) << 2);
            len4_reg <= len3_reg;
            s4_reg   <= s3_reg;
            ds4_reg  <= ds3_reg;

            lend_reg[0] <= h_len;
            for (int i = 1; i < DL; i++) begin
                lend_reg[i] <= lend_reg[i-1];
            end

            len_out_reg <= (C+2)'(lend_reg[DL-1]);
            vol_reg     <= vsat ? '1 : OW'(pvf >> VSH);
            area_reg    <= asat ? '1 : OW'(paf >> ASH);
            sat_reg     <= vsat || asat;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg       <= 1'b0;
            v2_reg       <= 1'b0;
            v3_reg       <= 1'b0;
            v4_reg       <= 1'b0;
            vd_reg       <= '0;
            m_tvalid_reg <= 1'b0;
        end else if (en) begin
            v1_reg       <= q_valid;
            v2_reg       <= v1_reg;
            v3_reg       <= l_valid;
            v4_reg       <= v3_reg;
            vd_reg       <= {vd_reg[DL-2:0], h_valid};
            m_tvalid_reg <= vd_reg[DL-1];
        end
    end

    fsmet_sqrt #(.IW(SQW), .PW(P1W)) u_sqrt_len (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (v2_reg),
        .n         (sq2_reg),
        .pay_in    ({s2_reg, dd2_reg, ds2_reg}),
        .out_valid (l_valid),
        .root      (l_root),
        .pay_out   (l_pay)
    );
    assign {l_s, l_dd, l_ds} = l_pay;

    fsmet_sqrt #(.IW(QW), .PW(P2W)) u_sqrt_slant (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (v4_reg),
        .n         (q4_reg),
        .pay_in    ({len4_reg, s4_reg, ds4_reg}),
        .out_valid (h_valid),
        .root      (h_root),
        .pay_out   (h_pay)
    );
    assign {h_len, h_s, h_ds} = h_pay;

    fsmet_mul #(.AW(LW), .BW(SQW)) u_mul_vol0 (
        .aclk (aclk), .en (en), .a (h_len), .b (h_s), .p (pv)
    );
    fsmet_mul #(.AW(C + 1), .BW(HW)) u_mul_area0 (
        .aclk (aclk), .en (en), .a (h_ds), .b (h_root), .p (pa)
    );
    fsmet_mul #(.AW(VW), .BW(fsmet_pkg::PI_FRAC)) u_mul_vol1 (
        .aclk (aclk), .en (en), .a (pv), .b (fsmet_pkg::PI12_Q48), .p (pvf)
    );
    fsmet_mul #(.AW(AW2), .BW(fsmet_pkg::PI_FRAC)) u_mul_area1 (
        .aclk (aclk), .en (en), .a (pa), .b (fsmet_pkg::PI4_Q48), .p (paf)
    );

    assign vsat = ((pvf >> (VSH + OW)) != '0);
    assign asat = ((paf >> (ASH + OW)) != '0);

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = MW'({area_reg, vol_reg, len_out_reg});
    assign m_tuser  = sat_reg;

endmodule

### rtl/frustum_segment_metrics_core.sv
// Top level of the frustum segment metrics block: front, queue and back part.
// Depends on fsmet_pkg, fsmet_front, fsmet_queue and fsmet_back.
//
// Channel  Direction  Handshake           Payload
// s_       in         s_tvalid/s_tready   s_tdata: prox x,y,z,diam, dist x,y,z,diam
// m_       out        m_tvalid/m_tready   m_tdata: length, volume, area; m_tuser: saturated
//
// One segment can be taken every cycle while the queue is not full, and one result
// leaves every cycle while m_tready is high; most depth is in the two square roots.
// Reset is synchronous and clears all valid bits and queue pointers.
// A stall on m_tready holds the back pipeline; the queue keeps taking inputs until full.
module frustum_segment_metrics_core #(
    parameter int COORD_WIDTH = 24,
    parameter int FRAC_BITS   = 8,
    localparam int S_TDATA_W  = 8 * COORD_WIDTH,
    localparam int M_TDATA_W  = ((COORD_WIDTH + 2 + 2*fsmet_pkg::OUT_WIDTH + 7) / 8) * 8
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // prox_x, prox_y, prox_z, prox_diam, dist_x, dist_y, dist_z, dist_diam
    input  logic [S_TDATA_W-1:0] s_tdata,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // seg_length, seg_volume, seg_area, zero fill
    output logic [M_TDATA_W-1:0] m_tdata,
    // saturated
    output logic                 m_tuser
);
    localparam int QDW = 5 * COORD_WIDTH;

    logic           q_full, q_push, q_pop, q_valid;
    logic [QDW-1:0] q_wdata, q_rdata;

    fsmet_front #(.C(COORD_WIDTH)) u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_data   (q_wdata)
    );

    fsmet_queue #(.W(QDW)) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .wdata     (q_wdata),
        .full      (q_full),
        .pop       (q_pop),
        .not_empty (q_valid),
        .rdata     (q_rdata)
    );

    fsmet_back #(.C(COORD_WIDTH), .F(FRAC_BITS), .MW(M_TDATA_W)) u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_valid  (q_valid),
        .q_data   (q_rdata),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

endmodule

### rtl/fsmet_checker.sv
// Port-level checks for the frustum segment metrics block, bound to its top level.
// Depends on fsmet_pkg and frustum_segment_metrics_core.
module fsmet_checker #(
    parameter int COORD_WIDTH = 24,
    parameter int FRAC_BITS   = 8,
    localparam int S_TDATA_W  = 8 * COORD_WIDTH,
    localparam int M_TDATA_W  = ((COORD_WIDTH + 2 + 2*fsmet_pkg::OUT_WIDTH + 7) / 8) * 8
) (
    input logic                 aclk,
    input logic                 aresetn,
    input logic                 s_tvalid,
    input logic                 s_tready,
    input logic [S_TDATA_W-1:0] s_tdata,
    input logic                 m_tvalid,
    input logic                 m_tready,
    input logic [M_TDATA_W-1:0] m_tdata,
    input logic                 m_tuser
);
    localparam int LEN_W = COORD_WIDTH + 2;
    localparam int OW    = fsmet_pkg::OUT_WIDTH;

    logic [LEN_W-1:0] len_f;
    logic [OW-1:0]    vol_f, area_f;

    assign len_f  = m_tdata[0 +: LEN_W];
    assign vol_f  = m_tdata[LEN_W +: OW];
    assign area_f = m_tdata[LEN_W + OW +: OW];

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("Result transfer dropped while stalled.");

    a_out_stable: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> $stable({m_tdata, m_tuser}))
        else $error("Result changed while stalled.");

    a_sat_clip: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser |-> (vol_f == '1) || (area_f == '1))
        else $error("Saturation flag set without a clipped value.");

    a_zero_len: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (len_f == '0) |-> (vol_f == '0))
        else $error("Nonzero volume for a zero-length segment.");

    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("Result valid right after reset.");

endmodule

bind frustum_segment_metrics_core fsmet_checker #(
    .COORD_WIDTH (COORD_WIDTH),
    .FRAC_BITS   (FRAC_BITS)
) u_fsmet_checker (.*);

### tb/frustum_segment_metrics_core_test.sv
// Self-checking testbench for frustum_segment_metrics_core: segment length, volume and area.
// Depends on fsmet_pkg and the core; a built-in predictor checks each result transfer in order.
`timescale 1ns / 1ps

module frustum_segment_metrics_core_test;

    localparam int CW        = 24;
    localparam int OW        = fsmet_pkg::OUT_WIDTH;
    localparam int LW        = CW + 2;
    localparam int S_W       = 8 * CW;
    localparam int M_W       = ((LW + 2*OW + 7) / 8) * 8;
    localparam int DRAIN     = 2*CW + 40;
    localparam int MAX_CYC   = 400000;
    localparam logic [255:0] PI12 = 256'(fsmet_pkg::PI12_Q48);
    localparam logic [255:0] PI4  = 256'(fsmet_pkg::PI4_Q48);

    typedef struct packed {
        logic [CW-1:0] dist_diam;
        logic [CW-1:0] dist_z;
        logic [CW-1:0] dist_y;
        logic [CW-1:0] dist_x;
        logic [CW-1:0] prox_diam;
        logic [CW-1:0] prox_z;
        logic [CW-1:0] prox_y;
        logic [CW-1:0] prox_x;
    } segment_t;

    typedef struct packed {
        logic          saturated;
        logic [OW-1:0] area;
        logic [OW-1:0] volume;
        logic [LW-1:0] length;
    } metrics_t;

    logic           aclk = 1'b0;
    logic           aresetn = 1'b0;
    logic           s_tvalid = 1'b0;
    logic           s_tready;
    // prox_x, prox_y, prox_z, prox_diam, dist_x, dist_y, dist_z, dist_diam
    logic [S_W-1:0] s_tdata = '0;
    logic           m_tvalid;
    logic           m_tready = 1'b0;
    // seg_length, seg_volume, seg_area, zero fill
    logic [M_W-1:0] m_tdata;
    // saturated
    logic           m_tuser;

    metrics_t expected_metrics[$];
    int       mismatch_count = 0;
    int       result_count = 0;
    int       sent_count = 0;
    int       saturated_count = 0;
    int       cycle_count = 0;
    int       hold_off_cycles = 0;
    bit       sink_steady = 1'b0;

    frustum_segment_metrics_core DUT (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
    );

    always #5 aclk = ~aclk;

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= MAX_CYC) begin
            $display("simulation failed");
            $finish;
        end
    end

    function automatic logic [63:0] floor_root(logic [255:0] n);
        logic [63:0]  r;
        logic [63:0]  c;
        logic [255:0] cw;
        r = '0;
        for (int b = 63; b >= 0; b--) begin
            c  = r | (64'd1 << b);
            cw = 256'(c);
            if (cw * cw <= n) r = c;
        end
        return r;
    endfunction

    function automatic logic [255:0] abs_delta(logic [CW-1:0] a, logic [CW-1:0] b);
        longint d;
        d = longint'($signed(a)) - longint'($signed(b));
        if (d < 0) d = -d;
        return 256'(d);
    endfunction

    function automatic metrics_t frustum_metrics(segment_t seg);
        metrics_t     m;
        logic [255:0] dx, dy, dz, d1, d2, len, s, v, dd, h, a;
        dx  = abs_delta(seg.prox_x, seg.dist_x);
        dy  = abs_delta(seg.prox_y, seg.dist_y);
        dz  = abs_delta(seg.prox_z, seg.dist_z);
        d1  = 256'(seg.prox_diam);
        d2  = 256'(seg.dist_diam);
        len = 256'(floor_root(dx*dx + dy*dy + dz*dz));
        s   = d1*d1 + d2*d2 + d1*d2;
        v   = (len * s * PI12) >> (2*8 + 48);
        dd  = (d1 > d2) ? d1 - d2 : d2 - d1;
        h   = 256'(floor_root(dd*dd + 4*len*len));
        a   = ((d1 + d2) * h * PI4) >> (8 + 48);
        m.length    = len[LW-1:0];
        m.saturated = 1'b0;
        if ((v >> OW) != 0) begin
            m.volume = '1;
            m.saturated = 1'b1;
        end else begin
            m.volume = v[OW-1:0];
        end
        if ((a >> OW) != 0) begin
            m.area = '1;
            m.saturated = 1'b1;
        end else begin
            m.area = a[OW-1:0];
        end
        return m;
    endfunction

    // Result side: transfers are sampled at the falling edge, where all inputs are stable.
    always @(negedge aclk) begin
        metrics_t got, want;
        if (aresetn && m_tvalid && m_tready) begin
            got.length    = m_tdata[LW-1:0];
            got.volume    = m_tdata[LW +: OW];
            got.area      = m_tdata[LW+OW +: OW];
            got.saturated = m_tuser;
            result_count++;
            if (got.saturated) saturated_count++;
            if (expected_metrics.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("unexpected result transfer: len %0d vol %0d area %0d sat %0b",
                             got.length, got.volume, got.area, got.saturated);
            end else begin
                want = expected_metrics.pop_front();
                if (got !== want) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display({"mismatch: expected len %0d vol %0d area %0d sat %0b,",
                                  " got len %0d vol %0d area %0d sat %0b"},
                                 want.length, want.volume, want.area, want.saturated,
                                 got.length, got.volume, got.area, got.saturated);
                end
            end
        end
    end

    // Result side ready: random stalls, quiet stretches, and long hold-offs on request.
    initial begin
        int run;
        @(posedge aresetn);
        forever begin
            if (hold_off_cycles > 0) begin
                m_tready <= 1'b0;
                repeat (hold_off_cycles) @(posedge aclk);
                hold_off_cycles = 0;
            end else if (sink_steady) begin
                m_tready <= 1'b1;
                @(posedge aclk);
            end else begin
                m_tready <= 1'b1;
                run = $urandom_range(1, 12);
                repeat (run) @(posedge aclk);
                m_tready <= 1'b0;
                run = ($urandom_range(0, 19) == 0) ? $urandom_range(20, 80)
                                                    : $urandom_range(1, 3);
                repeat (run) @(posedge aclk);
            end
        end
    end

    task automatic send_segment(segment_t seg, int gap);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= seg;
        @(negedge aclk);
        while (!s_tready) @(negedge aclk);
        @(posedge aclk);
        expected_metrics.push_back(frustum_metrics(seg));
        sent_count++;
    endtask

    function automatic int random_gap();
        case ($urandom_range(0, 9))
            0, 1, 2: return $urandom_range(1, 3);
            3:       return ($urandom_range(0, 4) == 0) ? $urandom_range(15, 60) : 0;
            default: return 0;
        endcase
    endfunction

    function automatic segment_t make_segment(int px, int py, int pz, int pd,
                                              int dx, int dy, int dz, int dd);
        segment_t seg;
        seg.prox_x = px[CW-1:0]; seg.prox_y = py[CW-1:0];
        seg.prox_z = pz[CW-1:0]; seg.prox_diam = pd[CW-1:0];
        seg.dist_x = dx[CW-1:0]; seg.dist_y = dy[CW-1:0];
        seg.dist_z = dz[CW-1:0]; seg.dist_diam = dd[CW-1:0];
        return seg;
    endfunction

    function automatic logic [CW-1:0] random_field(int scale);
        logic [CW-1:0] r;
        r = CW'($urandom);
        case (scale)
            0:       return CW'($signed(r[11:0]));
            1:       return CW'($signed(r[17:0]));
            default: return r;
        endcase
    endfunction

    task automatic wait_idle();
        s_tvalid <= 1'b0;
        wait (expected_metrics.size() == 0);
        @(posedge aclk);
    endtask

    task automatic test_directed();
        int mx, mn, md;
        mx = 8388607; mn = -8388608; md = 16777215;
        send_segment(make_segment(0, 0, 0, 0, 0, 0, 0, 0), 0);
        send_segment(make_segment(100, -5, 7, 512, 100, -5, 7, 256), 0);
        send_segment(make_segment(0, 0, 0, 0, 2560, 0, 0, 0), 1);
        send_segment(make_segment(0, 0, 0, 256, 768, 1024, 0, 256), 0);
        send_segment(make_segment(mn, mn, mn, md, mx, mx, mx, md), 0);
        send_segment(make_segment(mx, mx, mx, md, mn, mn, mn, md), 2);
        send_segment(make_segment(mn, 0, 0, md, mx, 0, 0, 0), 0);
        send_segment(make_segment(mn, mn, mn, 0, mx, mx, mx, 0), 0);
        send_segment(make_segment(mx, mx, mx, md, mx, mx, mx, 0), 0);
        send_segment(make_segment(mn, mn, mn, 0, mn, mn, mn, md), 0);
        send_segment(make_segment(-1, -1, -1, 1, 0, 0, 0, 1), 0);
        send_segment(make_segment(0, mn, 0, md, 0, mx, 0, md), 3);
        send_segment(make_segment(0, 0, mn, 1000000, 0, 0, mx, 9000000), 0);
        send_segment(make_segment(mx, 0, mn, 1, mn, 0, mx, 1), 0);
        send_segment(make_segment(-300, 400, 0, 100, 0, 0, 0, 300), 0);
        send_segment(make_segment(5, 5, 5, md, 5, 5, 5, md), 0);
        send_segment(make_segment(0, 0, 0, 1, 1, 0, 0, 0), 0);
        send_segment(make_segment(mn, mx, mn, 8388608, mx, mn, mx, 8388607), 0);
        wait_idle();
    endtask

    task automatic test_random(int count);
        segment_t seg;
        int       kind, scale;
        for (int i = 0; i < count; i++) begin
            kind  = $urandom_range(0, 9);
            scale = $urandom_range(0, 2);
            seg.prox_x = random_field(scale);
            seg.prox_y = random_field(scale);
            seg.prox_z = random_field(scale);
            seg.dist_x = random_field(scale);
            seg.dist_y = random_field(scale);
            seg.dist_z = random_field(scale);
            seg.prox_diam = CW'($urandom);
            seg.dist_diam = CW'($urandom);
            case (kind)
                0: begin
                    seg.dist_x = seg.prox_x;
                    seg.dist_y = seg.prox_y;
                    seg.dist_z = seg.prox_z;
                end
                1: begin
                    seg.prox_diam = '0;
                    seg.dist_diam = '0;
                end
                2: begin
                    seg.prox_diam = CW'($urandom_range(0, 4095));
                    seg.dist_diam = CW'($urandom_range(0, 4095));
                end
                3: begin
                    seg.prox_x = {1'b1, (CW-1)'($urandom)};
                    seg.dist_x = {1'b0, (CW-1)'($urandom)};
                    seg.prox_diam = '1 ^ CW'($urandom_range(0, 255));
                    seg.dist_diam = '1 ^ CW'($urandom_range(0, 255));
                end
                4: seg.dist_diam = seg.prox_diam;
                default: ;
            endcase
            send_segment(seg, random_gap());
        end
        wait_idle();
    endtask

    task automatic test_backpressure();
        segment_t seg;
        hold_off_cycles = 300;
        for (int i = 0; i < 150; i++) begin
            seg = make_segment($urandom_range(0, 60000), -7 * i, i, $urandom_range(0, 99999),
                               -$urandom_range(0, 60000), 3 * i, -i, $urandom_range(0, 99999));
            send_segment(seg, 0);
        end
        wait_idle();
    endtask

    task automatic test_steady_stream(int count);
        sink_steady = 1'b1;
        test_random(count);
        sink_steady = 1'b0;
    endtask

    initial begin
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed();
        test_random(400);
        test_backpressure();
        test_steady_stream(150);
        test_random(230);
        s_tvalid <= 1'b0;
        wait (expected_metrics.size() == 0);
        repeat (DRAIN) @(posedge aclk);
        $display("Sent %0d segments and checked %0d results (%0d saturated).",
                 sent_count, result_count, saturated_count);
        $display("Covered field extremes, coincident points, zero diameters and stalls.");
        if (mismatch_count == 0 && expected_metrics.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

### sim.f
rtl/fsmet_pkg.sv
rtl/fsmet_mul.sv
rtl/fsmet_sqrt.sv
rtl/fsmet_queue.sv
rtl/fsmet_front.sv
rtl/fsmet_back.sv
rtl/frustum_segment_metrics_core.sv
rtl/fsmet_checker.sv
tb/frustum_segment_metrics_core_test.sv
